// ----- src/block_bitmap_allocator_top_defines.svh -----
// Assertion macros used by the checker of the block bitmap allocator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define BBA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define BBA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bba_pkg.sv -----
// Shared types and constants of the block bitmap allocator.
// No dependencies; every other file of the block but bba_ram and the defines header imports it.
package bba_pkg;

	localparam int unsigned BBA_MAX_BLOCKS = 65536;
	localparam int unsigned BBA_WORD_BITS  = 32;

	localparam int unsigned BLK_W     = 16;
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_QUERY   = 2'd2,
		KIND_FORMAT  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL    = 1'b0,
		REG_RESERVED = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_FORMAT_START,
		OP_FILL_STEP,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_BIT,
		OP_NO_SPACE,
		OP_RANGE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  count_zero;
		logic  fill_last;
		logic  scan_found;
		logic  scan_idle;
		logic  out_free;
	} dp_stat_t;

endpackage

// ----- src/bba_if.sv -----
// Request and response channels of the block bitmap allocator.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
	import bba_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [$bits(kind_t)-1:0]  kind;
	logic [BLK_W-1:0]          block_number;

	modport source (output valid, kind, block_number, input ready);
	modport sink (input valid, kind, block_number, output ready);
endinterface

interface bba_rsp_if;
	import bba_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [BLK_W-1:0]           result_block;
	logic                       bit_value;
	logic [$bits(status_t)-1:0] status;
	logic [CNT_W-1:0]           free_blocks;

	modport source (output valid, result_block, bit_value, status, free_blocks, input ready);
	modport sink (input valid, result_block, bit_value, status, free_blocks, output ready);
endinterface

// ----- src/bba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bba_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 2048,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/bba_ctrl.sv -----
// Controller of the block bitmap allocator: sequences each item through the datapath.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bba_pkg::dp_stat_t   stat,
	output bba_pkg::ctrl_cmd_t  cmd
);
	import bba_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_READ,
		S_BIT,
		S_SCAN,
		S_FILL,
		S_RESP
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.load_out = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				// The map is swept once after reset before the first item is taken.
				cmd.op = OP_FILL_STEP;
				if (stat.fill_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_TAKE;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.kind) inside
					KIND_ALLOC: begin
						if (stat.count_zero) begin
							cmd.op  = OP_NO_SPACE;
							state_d = S_RESP;
						end else begin
							cmd.op  = OP_SCAN_START;
							state_d = S_SCAN;
						end
					end
					KIND_RELEASE, KIND_QUERY: begin
						if (stat.in_range) begin
							state_d = S_READ;
						end else begin
							cmd.op  = OP_RANGE;
							state_d = S_RESP;
						end
					end
					KIND_FORMAT: begin
						cmd.op  = OP_FORMAT_START;
						state_d = S_FILL;
					end
				endcase
			end
			S_READ: begin
				state_d = S_BIT;
			end
			S_BIT: begin
				cmd.op  = OP_BIT;
				state_d = S_RESP;
			end
			S_SCAN: begin
				cmd.op = OP_SCAN_STEP;
				if (stat.scan_found || stat.scan_idle) begin
					state_d = S_RESP;
				end
			end
			S_FILL: begin
				cmd.op = OP_FILL_STEP;
				if (stat.fill_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ----- src/bba_dp.sv -----
// Datapath of the block bitmap allocator: configuration, free count, map RAM,
// word scan pipeline, bit access and the output register. Depends on bba_pkg and bba_ram.
module bba_dp #(
	parameter int unsigned MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS,
	parameter int unsigned WORD_BITS  = bba_pkg::BBA_WORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]           cfg_data,
	input  logic [$bits(bba_pkg::kind_t)-1:0]   in_kind,
	input  logic [bba_pkg::BLK_W-1:0]           in_block,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [bba_pkg::BLK_W-1:0]           out_result_block,
	output logic                                out_bit_value,
	output logic [$bits(bba_pkg::status_t)-1:0] out_status,
	output logic [bba_pkg::CNT_W-1:0]           out_free_blocks,
	input  bba_pkg::ctrl_cmd_t                  cmd,
	output bba_pkg::dp_stat_t                   stat
);
	import bba_pkg::*;

	localparam int unsigned DEPTH  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SPAN_W = $clog2(DEPTH * WORD_BITS + 1);
	localparam int unsigned BASE_W = (SPAN_W > CNT_W + 1) ? SPAN_W : CNT_W + 1;
	localparam int unsigned KW     = $clog2(WORD_BITS + 1);
	localparam int unsigned RW     = $clog2(WORD_BITS);
	localparam int unsigned PW     = 1 << RW;
	localparam int unsigned TOTAL_CLIP =
		(MAX_BLOCKS < (1 << CNT_W)) ? MAX_BLOCKS : (1 << CNT_W) - 1;
	// Word index of a block number by reciprocal multiplication, exact for every
	// block number of BLK_W bits.
	localparam int unsigned SH = BLK_W + RW;
	localparam int unsigned MW = SH + 1;
	localparam int unsigned PROD_W = BLK_W + MW;
	localparam longint unsigned RECIP = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam logic [WORD_BITS-1:0] MSB_ONE = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Mask with the k leading (lowest numbered) blocks of a word set.
	function automatic logic [WORD_BITS-1:0] top_bits(input logic [KW-1:0] k);
		top_bits = ~({WORD_BITS{1'b1}} >> k);
	endfunction

	// Number of blocks of the word starting at base that lie below lim, at most one word.
	function automatic logic [KW-1:0] clamp_k(input logic [BASE_W-1:0] lim,
			input logic [BASE_W-1:0] base);
		logic [BASE_W-1:0] d;
		d = lim - base;
		if (base >= lim) begin
			clamp_k = '0;
		end else if (d >= BASE_W'(WORD_BITS)) begin
			clamp_k = KW'(WORD_BITS);
		end else begin
			clamp_k = d[KW-1:0];
		end
	endfunction

	// Offset of the first set bit counted from the MSB, by halving the window.
	function automatic logic [RW-1:0] first_free(input logic [WORD_BITS-1:0] f);
		logic [PW-1:0] v;
		logic [PW-1:0] w;
		logic [RW-1:0] idx;
		v   = PW'(f) << (PW - WORD_BITS);
		idx = '0;
		for (int lvl = RW - 1; lvl >= 0; lvl--) begin
			w = v << idx;
			if ((w >> (PW - (1 << lvl))) == '0) begin
				idx = idx + RW'(1 << lvl);
			end
		end
		first_free = idx;
	endfunction

	// Configuration and control state
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  reserved_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  fill_res_q;
	logic [AW-1:0]     addr_q;
	logic [BASE_W-1:0] base_q;
	logic              out_valid_q;

	// Scan pipeline
	logic              v_s1;
	logic              v_s2;
	logic [BASE_W-1:0] base_s1;
	logic [BASE_W-1:0] base_s2;
	logic [AW-1:0]     addr_s1;
	logic [AW-1:0]     addr_s2;
	logic [WORD_BITS-1:0] free_s2;
	logic [WORD_BITS-1:0] word_s2;

	// Item payload and results
	kind_t             kind_q;
	logic [BLK_W-1:0]  blk_q;
	logic [BLK_W-1:0]  q_q;
	logic [RW-1:0]     r_q;
	logic [BLK_W-1:0]  res_block_q;
	logic              res_bit_q;
	status_t           res_status_q;
	logic [BLK_W-1:0]  out_block_q;
	logic              out_bit_q;
	status_t           out_status_q;
	logic [CNT_W-1:0]  out_count_q;

	// RAM port signals
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [CNT_W-1:0]     eff_total;
	logic [CNT_W-1:0]     eff_res;
	logic [BASE_W-1:0]    eff_base;
	logic                 issue;
	logic                 found;
	logic                 scan_idle;
	logic [WORD_BITS-1:0] free_vec;
	logic [RW-1:0]        hit_idx;
	logic [WORD_BITS-1:0] alloc_word;
	logic [WORD_BITS-1:0] bit_sel;
	logic                 cur_bit;
	logic [WORD_BITS-1:0] fill_word;
	logic [PROD_W-1:0]    prod;
	logic [BLK_W-1:0]     quot;
	logic [BLK_W-1:0]     rem_full;
	logic                 release_set;

	assign eff_total = (total_q > CNT_W'(TOTAL_CLIP)) ? CNT_W'(TOTAL_CLIP) : total_q;
	assign eff_res   = (reserved_q > eff_total) ? eff_total : reserved_q;
	assign eff_base  = BASE_W'(eff_total);

	assign issue     = base_q < eff_base;
	assign found     = v_s2 && (free_s2 != '0);
	assign scan_idle = !issue && !v_s1 && !v_s2;
	// Blocks at or beyond the total count as used so the scan never returns them.
	assign free_vec   = ~ram_rdata & top_bits(clamp_k(eff_base, base_s1));
	assign hit_idx    = first_free(free_s2);
	assign alloc_word = word_s2 | (MSB_ONE >> hit_idx);
	assign bit_sel    = MSB_ONE >> r_q;
	assign cur_bit    = (ram_rdata & bit_sel) != '0;
	assign fill_word  = top_bits(clamp_k(BASE_W'(fill_res_q), base_q));
	assign release_set = (kind_q == KIND_RELEASE) && cur_bit;

	assign prod     = PROD_W'(blk_q) * PROD_W'(RECIP);
	assign quot     = BLK_W'(prod >> SH);
	assign rem_full = blk_q - q_q * BLK_W'(WORD_BITS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = fill_word;
		ram_raddr = (cmd.op == OP_SCAN_STEP) ? addr_q : AW'(q_q);
		unique case (cmd.op)
			OP_FILL_STEP: begin
				ram_we = 1'b1;
			end
			OP_SCAN_STEP: begin
				if (found) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s2;
					ram_wdata = alloc_word;
				end
			end
			OP_BIT: begin
				if (release_set) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(q_q);
					ram_wdata = ram_rdata & ~bit_sel;
				end
			end
			default: begin
			end
		endcase
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(AW)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= TOTAL_RESET;
			reserved_q  <= '0;
			count_q     <= '0;
			fill_res_q  <= '0;
			addr_q      <= '0;
			base_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_TOTAL:    total_q    <= cfg_data;
					REG_RESERVED: reserved_q <= cfg_data;
				endcase
			end
			v_s1 <= (cmd.op == OP_SCAN_STEP) && issue;
			v_s2 <= (cmd.op == OP_SCAN_STEP) && v_s1;
			unique case (cmd.op)
				OP_FORMAT_START: begin
					addr_q     <= '0;
					base_q     <= '0;
					fill_res_q <= eff_res;
					count_q    <= eff_total - eff_res;
				end
				OP_SCAN_START: begin
					addr_q <= '0;
					base_q <= '0;
				end
				OP_FILL_STEP: begin
					addr_q <= AW'(addr_q + 1'b1);
					base_q <= base_q + BASE_W'(WORD_BITS);
				end
				OP_SCAN_STEP: begin
					if (issue) begin
						addr_q <= AW'(addr_q + 1'b1);
						base_q <= base_q + BASE_W'(WORD_BITS);
					end
					if (found) begin
						count_q <= count_q - 1'b1;
					end
				end
				OP_BIT: begin
					if (release_set && (count_q != COUNT_MAX)) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_TAKE) begin
			kind_q <= kind_t'(in_kind);
			blk_q  <= in_block;
		end
		q_q     <= quot;
		r_q     <= RW'(rem_full);
		base_s1 <= base_q;
		addr_s1 <= addr_q;
		base_s2 <= base_s1;
		addr_s2 <= addr_s1;
		word_s2 <= ram_rdata;
		free_s2 <= free_vec;
		unique case (cmd.op)
			OP_FORMAT_START: begin
				res_block_q  <= '0;
				res_bit_q    <= 1'b0;
				res_status_q <= ST_OK;
			end
			OP_SCAN_STEP: begin
				if (found) begin
					res_block_q  <= BLK_W'(base_s2 + BASE_W'(hit_idx));
					res_bit_q    <= 1'b1;
					res_status_q <= ST_OK;
				end else if (scan_idle) begin
					res_block_q  <= '0;
					res_bit_q    <= 1'b0;
					res_status_q <= ST_NO_SPACE;
				end
			end
			OP_NO_SPACE: begin
				res_block_q  <= '0;
				res_bit_q    <= 1'b0;
				res_status_q <= ST_NO_SPACE;
			end
			OP_RANGE: begin
				res_block_q  <= blk_q;
				res_bit_q    <= 1'b0;
				res_status_q <= ST_RANGE;
			end
			OP_BIT: begin
				res_block_q  <= blk_q;
				res_bit_q    <= (kind_q == KIND_QUERY) && cur_bit;
				res_status_q <= ST_OK;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_block_q  <= res_block_q;
			out_bit_q    <= res_bit_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign stat.kind       = kind_q;
	assign stat.in_range   = {1'b0, blk_q} < eff_total;
	assign stat.count_zero = count_q == '0;
	assign stat.fill_last  = addr_q == AW'(DEPTH - 1);
	assign stat.scan_found = found;
	assign stat.scan_idle  = scan_idle;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign out_result_block = out_block_q;
	assign out_bit_value    = out_bit_q;
	assign out_status       = out_status_q;
	assign out_free_blocks  = out_count_q;
endmodule

// ----- src/block_bitmap_allocator_top.sv -----
// Top level of the block bitmap allocator: controller, datapath and map RAM.
// Depends on bba_pkg, bba_if, bba_ctrl, bba_dp and bba_ram.
//
// First-fit block allocator over a one-bit-per-block usage map held in a RAM of
// ceil(MAX_BLOCKS/WORD_BITS) words, plus a free-block count. One item is worked on at a
// time. After reset the block clears the map, one word per cycle, and takes no item
// until that pass is done; configuration writes are taken during that pass. Release and
// query decode, read the map word, then take the bit and register the result. Allocate
// scans the map one word per cycle through the RAM read port, up to the first word with a
// free block or to the end of the total; with a zero count it answers no space without a
// scan. Format rewrites every map word, one per cycle. The result sits in an output
// register, so a new item is accepted while the previous result still waits to be taken.
module block_bitmap_allocator_top #(
	parameter int unsigned MAX_BLOCKS = bba_pkg::BBA_MAX_BLOCKS,
	parameter int unsigned WORD_BITS  = bba_pkg::BBA_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::CNT_W-1:0]     cfg_data,
	bba_req_if.sink                       req,
	bba_rsp_if.source                     rsp
);
	import bba_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	bba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_kind         (req.kind),
		.in_block        (req.block_number),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_result_block(rsp.result_block),
		.out_bit_value   (rsp.bit_value),
		.out_status      (rsp.status),
		.out_free_blocks (rsp.free_blocks),
		.cmd             (cmd),
		.stat            (stat)
	);
endmodule

// ----- src/bba_checker.sv -----
// Port-level checker of the block bitmap allocator and its bind to the top level.
// Depends on bba_pkg and block_bitmap_allocator_top_defines.svh.
`include "block_bitmap_allocator_top_defines.svh"

module bba_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [bba_pkg::BLK_W-1:0]           rsp_result_block,
	input logic                                rsp_bit_value,
	input logic [$bits(bba_pkg::status_t)-1:0] rsp_status,
	input logic [bba_pkg::CNT_W-1:0]           rsp_free_blocks
);
	import bba_pkg::*;

	// A stalled result keeps every field until it is taken.
	`BBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_block) && $stable(rsp_bit_value) && $stable(rsp_status) && $stable(rsp_free_blocks), "response changed while stalled")

	// Only one item is in work at a time.
	`BBA_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "request taken while busy")

	`BBA_ASSERT_NOW(a_no_space_zero, rsp_valid && (rsp_status == ST_NO_SPACE), (rsp_result_block == '0) && !rsp_bit_value, "failed allocate reports a block")

	`BBA_ASSERT_NOW(a_range_clear, rsp_valid && (rsp_status == ST_RANGE), !rsp_bit_value, "out-of-range item reports a set bit")
endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_result_block(rsp.result_block),
	.rsp_bit_value   (rsp.bit_value),
	.rsp_status      (rsp.status),
	.rsp_free_blocks (rsp.free_blocks)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the block bitmap allocator: random and directed requests
// checked against a shadow copy of the usage map and free-block count.
// Depends on bba_pkg, bba_if and block_bitmap_allocator_top.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int unsigned MAP_WORDS = BBA_MAX_BLOCKS / BBA_WORD_BITS;
	localparam int RUN_LIMIT = 4_000_000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int HOLD_CYCLES = 300;

	typedef bit [BBA_WORD_BITS-1:0] map_word_t;
	localparam map_word_t FULL_WORD = '1;

	typedef struct packed {
		kind_t            kind;
		logic [BLK_W-1:0] blk;
	} request_t;

	typedef struct packed {
		logic [BLK_W-1:0] block;
		logic             used;
		status_t          status;
		logic [CNT_W-1:0] free_blocks;
	} outcome_t;

	typedef enum {RX_STEADY, RX_HALF, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	kind_t req_kind = KIND_ALLOC;
	logic [BLK_W-1:0] req_blk = '0;
	logic rsp_ready = 1'b0;

	bba_req_if req_if ();
	bba_rsp_if rsp_if ();

	assign req_if.valid = req_valid;
	assign req_if.kind = req_kind;
	assign req_if.block_number = req_blk;
	assign rsp_if.ready = rsp_ready;

	block_bitmap_allocator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #1 clk = ~clk;

	// Shadow state of the allocator.
	map_word_t used_words [MAP_WORDS];
	logic [CNT_W-1:0] shadow_free = '0;
	logic [CNT_W-1:0] cfg_total = TOTAL_RESET;
	logic [CNT_W-1:0] cfg_reserved = '0;

	request_t pending_q [$];
	outcome_t expected_outcomes [$];
	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	bit hold_started = 1'b0;
	rx_mode_t rx_mode = RX_STEADY;
	int rx_mode_left = 0;

	initial begin
		foreach (used_words[w])
			used_words[w] = '0;
	end

	function automatic int unsigned effective_total();
		return (cfg_total > BBA_MAX_BLOCKS) ? BBA_MAX_BLOCKS : int'(cfg_total);
	endfunction

	// Applies one request to the shadow state and returns the result it must produce.
	function automatic outcome_t apply_request(request_t rq);
		outcome_t o;
		int unsigned total, res, w, b, n;
		bit found;
		total = effective_total();
		o = '0;
		o.status = ST_OK;
		case (rq.kind)
			KIND_ALLOC: begin
				o.status = ST_NO_SPACE;
				found = 1'b0;
				n = 0;
				if (shadow_free != 0) begin
					for (w = 0; w < (total + BBA_WORD_BITS - 1) / BBA_WORD_BITS && !found; w++) begin
						if (used_words[w] == FULL_WORD)
							continue;
						for (b = 0; b < BBA_WORD_BITS && !found; b++) begin
							if (w * BBA_WORD_BITS + b >= total)
								break;
							if (!used_words[w][BBA_WORD_BITS-1-b]) begin
								found = 1'b1;
								n = w * BBA_WORD_BITS + b;
							end
						end
					end
				end
				// A nonzero count with no clear bit below the total still fails.
				if (found) begin
					used_words[n / BBA_WORD_BITS][BBA_WORD_BITS-1-(n % BBA_WORD_BITS)] = 1'b1;
					shadow_free = shadow_free - 1'b1;
					o.block = n[BLK_W-1:0];
					o.used = 1'b1;
					o.status = ST_OK;
				end
			end
			KIND_RELEASE, KIND_QUERY: begin
				o.block = rq.blk;
				if (rq.blk >= total) begin
					o.status = ST_RANGE;
				end else begin
					w = rq.blk / BBA_WORD_BITS;
					b = BBA_WORD_BITS - 1 - (rq.blk % BBA_WORD_BITS);
					if (rq.kind == KIND_RELEASE) begin
						// Releasing a block that is already free leaves the count alone.
						if (used_words[w][b]) begin
							used_words[w][b] = 1'b0;
							if (shadow_free != COUNT_MAX)
								shadow_free = shadow_free + 1'b1;
						end
					end else begin
						o.used = used_words[w][b];
					end
				end
			end
			default: begin
				res = (cfg_reserved > total) ? total : int'(cfg_reserved);
				for (w = 0; w < MAP_WORDS; w++) begin
					if ((w + 1) * BBA_WORD_BITS <= res)
						used_words[w] = FULL_WORD;
					else if (w * BBA_WORD_BITS >= res)
						used_words[w] = '0;
					else
						used_words[w] = ~(FULL_WORD >> (res - w * BBA_WORD_BITS));
				end
				shadow_free = CNT_W'(total - res);
			end
		endcase
		o.free_blocks = shadow_free;
		return o;
	endfunction

	// Block numbers cluster around the edge of the reserved area and the total,
	// with some fully random ones so that every bit of the field toggles.
	function automatic request_t random_request();
		request_t rq;
		int unsigned total, res, lo, hi, pick;
		total = effective_total();
		res = (cfg_reserved > total) ? total : int'(cfg_reserved);
		lo = (res > 8) ? res - 8 : 0;
		hi = lo + ((total - lo + 3 < 72) ? total - lo + 3 : 72);
		if (hi > 65535)
			hi = 65535;
		pick = $urandom_range(99, 0);
		if (pick < 45)
			rq.kind = KIND_ALLOC;
		else if (pick < 72)
			rq.kind = KIND_RELEASE;
		else if (pick < 97)
			rq.kind = KIND_QUERY;
		else
			rq.kind = KIND_FORMAT;
		if ($urandom_range(9, 0) < 2)
			rq.blk = BLK_W'($urandom);
		else
			rq.blk = BLK_W'($urandom_range(hi, lo));
		return rq;
	endfunction

	function automatic void queue_request(kind_t kind, logic [BLK_W-1:0] blk);
		request_t rq;
		rq.kind = kind;
		rq.blk = blk;
		pending_q.push_back(rq);
	endfunction

	function automatic void report_failure(string msg);
		fail_count++;
		if (fail_count <= SHOWN_MISMATCHES)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endfunction

	task automatic program_regs(logic [CNT_W-1:0] total, logic [CNT_W-1:0] reserved);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TOTAL;
		cfg_data <= total;
		@(posedge clk);
		cfg_index <= REG_RESERVED;
		cfg_data <= reserved;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_total = total;
		cfg_reserved = reserved;
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || req_valid || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(logic [CNT_W-1:0] total, logic [CNT_W-1:0] reserved,
			bit do_format, int count);
		wait_drained();
		program_regs(total, reserved);
		if (do_format)
			queue_request(KIND_FORMAT, '0);
		repeat (count)
			pending_q.push_back(random_request());
	endtask

	// Request side: items go out in bursts with random gaps between them.
	always @(posedge clk) begin : sender
		request_t nxt;
		if (arst_n) begin
			if (req_valid && req_if.ready) begin
				nxt.kind = req_kind;
				nxt.blk = req_blk;
				expected_outcomes.push_back(apply_request(nxt));
			end
			if (!req_valid || req_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					req_valid <= 1'b1;
					req_kind <= nxt.kind;
					req_blk <= nxt.blk;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(12, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started once on request.
	always @(posedge clk) begin
		if (hold_request && !hold_started) begin
			hold_started <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Response side: compare each accepted item with the oldest expectation.
	always @(posedge clk) begin : receiver
		outcome_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_ready) begin
				if (expected_outcomes.size() == 0) begin
					report_failure($sformatf("unexpected result block %0d bit %0d status %0d free %0d",
						rsp_if.result_block, rsp_if.bit_value, rsp_if.status,
						rsp_if.free_blocks));
				end else begin
					want = expected_outcomes.pop_front();
					if (rsp_if.result_block !== want.block || rsp_if.bit_value !== want.used ||
							rsp_if.status !== want.status ||
							rsp_if.free_blocks !== want.free_blocks)
						report_failure($sformatf(
							"expected block %0d bit %0d status %0d free %0d, got %0d %0d %0d %0d",
							want.block, want.used, want.status, want.free_blocks,
							rsp_if.result_block, rsp_if.bit_value, rsp_if.status,
							rsp_if.free_blocks));
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(2, 0));
				rx_mode_left <= $urandom_range(80, 10);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			if (hold_left != 0) begin
				rsp_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY: rsp_ready <= 1'b1;
					RX_HALF: rsp_ready <= ($urandom_range(1, 0) == 1);
					default: rsp_ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("block_bitmap_allocator_top regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Before any format the count is zero and the map clear.
		program_regs(TOTAL_RESET, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_RELEASE, 16'd5);
		queue_request(KIND_QUERY, 16'hFFFF);
		queue_request(KIND_FORMAT, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_ALLOC, 16'hFFFF);
		queue_request(KIND_QUERY, 16'd1);
		queue_request(KIND_RELEASE, 16'd0);
		queue_request(KIND_RELEASE, 16'd0);
		queue_request(KIND_ALLOC, '0);
		wait_drained();

		// Tiny device: fill it, run out of space, step past the total.
		program_regs(17'd5, 17'd3);
		queue_request(KIND_FORMAT, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_RELEASE, 16'd5);
		queue_request(KIND_QUERY, 16'hFFFF);
		queue_request(KIND_RELEASE, 16'd4);
		queue_request(KIND_QUERY, 16'd4);
		wait_drained();

		// Register maxima clamp to the map size; everything ends up reserved.
		program_regs('1, '1);
		queue_request(KIND_FORMAT, '0);
		queue_request(KIND_RELEASE, 16'hFFFF);
		wait_drained();

		// Shrinking the total leaves a count with no free block below it.
		program_regs(17'd1, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_FORMAT, '0);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_ALLOC, '0);

		wait_drained();
		run_phase(17'd64, '0, 1'b1, 90);
		run_phase(17'd37, 17'd5, 1'b1, 80);
		run_phase(17'd1, '0, 1'b1, 40);
		run_phase(17'd100, '1, 1'b1, 60);
		// Map and count are kept across this change; only the range moves. The
		// receiver holds off while short items keep coming, so the input stalls.
		wait_drained();
		program_regs(17'd200, 17'd7);
		hold_request = 1'b1;
		queue_request(KIND_QUERY, 16'd0);
		queue_request(KIND_QUERY, 16'd150);
		queue_request(KIND_RELEASE, 16'd2);
		queue_request(KIND_ALLOC, '0);
		queue_request(KIND_QUERY, 16'd2);
		queue_request(KIND_QUERY, 16'd250);
		repeat (54)
			pending_q.push_back(random_request());
		run_phase('1, 17'd65530, 1'b1, 40);
		run_phase(17'd33, 17'd32, 1'b1, 100);
		wait_drained();

		repeat (100) @(posedge clk);
		if (expected_outcomes.size() != 0)
			$display("%0d expected results never arrived", expected_outcomes.size());
		if (fail_count == 0 && expected_outcomes.size() == 0)
			$display("block_bitmap_allocator_top regression: pass");
		else
			$display("block_bitmap_allocator_top regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/bba_pkg.sv
src/bba_if.sv
src/bba_ram.sv
src/bba_ctrl.sv
src/bba_dp.sv
src/block_bitmap_allocator_top.sv
src/bba_checker.sv
verif/tb_top.sv
